[src/assert_macros.svh]
// Assertion macros for the RTL files of the date adder.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/gda_pkg.sv]
// Package of the Gregorian date adder: widths, calendar constants, types and helpers.
// No dependencies; used by the interfaces, the arithmetic unit and the top level.
package gda_pkg;

    // Field widths.
    localparam int ADD_WIDTH   = 16;
    localparam int DAY_W       = 5;
    localparam int MONTH_W     = 4;
    localparam int YEAR_W      = 14;

    // The running day count must hold a full year, a day and the added count.
    localparam int REM_W       = ADD_WIDTH + 2;
    localparam int CYC_W       = 18;
    localparam int ALU_W       = (REM_W > CYC_W) ? REM_W : CYC_W;

    // Calendar constants.
    localparam int unsigned DAYS_PER_CYCLE  = 146097;
    localparam int unsigned YEARS_PER_CYCLE = 400;
    localparam int unsigned LEAP_FEB_LEN    = 29;
    localparam int unsigned MONTHS_PER_YEAR = 12;
    localparam int unsigned DAYS_LEAP_YEAR  = 366;
    localparam int unsigned DAYS_YEAR       = 365;

    localparam logic [DAY_W-1:0] MONTH_LEN [MONTHS_PER_YEAR] =
        '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
          5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

    localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_YMOD,
        S_MSUM,
        S_CYC,
        S_YEAR,
        S_MON
    } t_state;

    // Result of the shared add/subtract/compare unit.
    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             gt;
        logic             ge;
    } t_alu_out;

    // Leap test on a year already reduced modulo 400.
    function automatic logic f_is_leap(input logic [YEAR_W-1:0] ymod);
        logic century;
        century = (ymod == YEAR_W'(100)) || (ymod == YEAR_W'(200)) ||
                  (ymod == YEAR_W'(300));
        return (ymod == '0) || ((ymod[1:0] == 2'b00) && !century);
    endfunction

    // Length of a month; months outside January..December have length zero.
    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m,
                                                     input logic             leap);
        logic [MONTH_W-1:0] idx;
        idx = m - MONTH_W'(1);
        if ((m == '0) || (m > MONTH_W'(MONTHS_PER_YEAR))) begin
            return '0;
        end else if ((m == FEBRUARY) && leap) begin
            return DAY_W'(LEAP_FEB_LEN);
        end else begin
            return MONTH_LEN[idx];
        end
    endfunction

endpackage

[src/gda_if.sv]
// Request and response channel interfaces of the Gregorian date adder.
// Depends on gda_pkg for the field widths.
interface gda_req_if;
    logic                              valid;
    logic                              ready;
    logic [gda_pkg::DAY_W-1:0]         start_day;
    logic [gda_pkg::MONTH_W-1:0]       start_month;
    logic [gda_pkg::YEAR_W-1:0]        start_year;
    logic [gda_pkg::ADD_WIDTH-1:0]     days_to_add;

    modport source (output valid, start_day, start_month, start_year, days_to_add,
                    input ready);
    modport sink   (input valid, start_day, start_month, start_year, days_to_add,
                    output ready);
endinterface

interface gda_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [gda_pkg::DAY_W-1:0]         result_day;
    logic [gda_pkg::MONTH_W-1:0]       result_month;
    logic [gda_pkg::YEAR_W-1:0]        result_year;

    modport source (output valid, result_day, result_month, result_year,
                    input ready);
    modport sink   (input valid, result_day, result_month, result_year,
                    output ready);
endinterface

[src/gda_alu.sv]
// Shared add/subtract/compare unit of the Gregorian date adder.
// Depends on gda_pkg for the operand width and the result struct.
module gda_alu (
    input  logic [gda_pkg::ALU_W-1:0] i_a,
    input  logic [gda_pkg::ALU_W-1:0] i_b,
    input  logic                      i_sub,
    output gda_pkg::t_alu_out         o_out
);

    // One adder serves both directions; the compares use the same operands.
    always_comb begin
        o_out.res = i_sub ? (i_a - i_b) : (i_a + i_b);
        o_out.gt  = (i_a > i_b);
        o_out.ge  = (i_a >= i_b);
    end

endmodule

[src/gregorian_date_add_days.sv]
// Top level of the Gregorian date adder: sequencer, registers and output stage.
// Depends on gda_pkg, gda_if.sv, gda_alu and assert_macros.svh.
//
// Adds a day count to a Gregorian date and returns the resulting date; the day
// field is an unchecked offset that carries into later months. One request is
// worked on at a time, and i_req.ready is low while it is in progress. The day
// arithmetic and the modulo-400 reduction use the shared add/subtract/compare
// unit, one step per cycle: the year is reduced modulo 400, the earlier months
// are summed, whole 400-year cycles are skipped, whole years are walked one per
// cycle, and finally months one per cycle (at most 12), after which the result
// waits until the output register is free. The year walk dominates the run time.
// A finished response waits in an output register, so a new request is taken
// while it is still pending.
`include "assert_macros.svh"

module gregorian_date_add_days (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gda_req_if.sink    i_req,
    gda_rsp_if.source  o_rsp
);

    gda_pkg::t_state                  r_state,      n_state;
    logic [gda_pkg::ALU_W-1:0]        r_rem,        n_rem;
    logic [gda_pkg::YEAR_W-1:0]       r_year,       n_year;
    logic [gda_pkg::YEAR_W-1:0]       r_ymod,       n_ymod;
    logic [gda_pkg::MONTH_W-1:0]      r_month_in,   n_month_in;
    logic [gda_pkg::MONTH_W-1:0]      r_m,          n_m;
    logic                             r_out_valid,  n_out_valid;
    logic [gda_pkg::DAY_W-1:0]        r_out_day,    n_out_day;
    logic [gda_pkg::MONTH_W-1:0]      r_out_month,  n_out_month;
    logic [gda_pkg::YEAR_W-1:0]       r_out_year,   n_out_year;

    logic [gda_pkg::ALU_W-1:0]        alu_a;
    logic [gda_pkg::ALU_W-1:0]        alu_b;
    logic                             alu_sub;
    gda_pkg::t_alu_out                alu_out;
    logic                             leap;

    gda_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_out (alu_out)
    );

    // Leap flag of the year currently being walked.
    assign leap = gda_pkg::f_is_leap(r_ymod);

    // Handshake and response payload.
    assign i_req.ready        = (r_state == gda_pkg::S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_day   = r_out_day;
    assign o_rsp.result_month = r_out_month;
    assign o_rsp.result_year  = r_out_year;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gda_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_year      <= n_year;
        r_ymod      <= n_ymod;
        r_month_in  <= n_month_in;
        r_m         <= n_m;
        r_out_day   <= n_out_day;
        r_out_month <= n_out_month;
        r_out_year  <= n_out_year;
    end

    // Sequencer: each state issues one operation to the shared unit.
    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_year      = r_year;
        n_ymod      = r_ymod;
        n_month_in  = r_month_in;
        n_m         = r_m;
        n_out_valid = r_out_valid;
        n_out_day   = r_out_day;
        n_out_month = r_out_month;
        n_out_year  = r_out_year;
        alu_a       = r_rem;
        alu_b       = '0;
        alu_sub     = 1'b1;

        // The pending response leaves when the sink takes it.
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            gda_pkg::S_IDLE: begin
                // Start with day plus added count; the earlier months follow.
                alu_a   = gda_pkg::ALU_W'(i_req.start_day);
                alu_b   = gda_pkg::ALU_W'(i_req.days_to_add);
                alu_sub = 1'b0;
                if (i_req.valid) begin
                    n_rem      = alu_out.res;
                    n_year     = i_req.start_year;
                    n_ymod     = i_req.start_year;
                    n_month_in = i_req.start_month;
                    n_state    = gda_pkg::S_YMOD;
                end
            end
            gda_pkg::S_YMOD: begin
                // Reduce the year modulo 400 by repeated subtraction.
                alu_a = gda_pkg::ALU_W'(r_ymod);
                alu_b = gda_pkg::ALU_W'(gda_pkg::YEARS_PER_CYCLE);
                if (alu_out.ge) begin
                    n_ymod = alu_out.res[gda_pkg::YEAR_W-1:0];
                end else begin
                    n_m     = gda_pkg::MONTH_W'(1);
                    n_state = gda_pkg::S_MSUM;
                end
            end
            gda_pkg::S_MSUM: begin
                // Add the lengths of the months before the start month.
                alu_b   = gda_pkg::ALU_W'(gda_pkg::f_month_len(r_m, leap));
                alu_sub = 1'b0;
                if (r_m < r_month_in) begin
                    n_rem = alu_out.res;
                    n_m   = r_m + gda_pkg::MONTH_W'(1);
                end else begin
                    n_state = gda_pkg::S_CYC;
                end
            end
            gda_pkg::S_CYC: begin
                // Skip whole 400-year cycles.
                alu_b = gda_pkg::ALU_W'(gda_pkg::DAYS_PER_CYCLE);
                if (alu_out.gt) begin
                    n_rem  = alu_out.res;
                    n_year = r_year + gda_pkg::YEAR_W'(gda_pkg::YEARS_PER_CYCLE);
                end else begin
                    n_state = gda_pkg::S_YEAR;
                end
            end
            gda_pkg::S_YEAR: begin
                // Walk whole years, keeping the year modulo 400 in step.
                alu_b = leap ? gda_pkg::ALU_W'(gda_pkg::DAYS_LEAP_YEAR)
                             : gda_pkg::ALU_W'(gda_pkg::DAYS_YEAR);
                if (alu_out.gt) begin
                    n_rem  = alu_out.res;
                    n_year = r_year + gda_pkg::YEAR_W'(1);
                    if (r_ymod == gda_pkg::YEAR_W'(gda_pkg::YEARS_PER_CYCLE - 1)) begin
                        n_ymod = '0;
                    end else begin
                        n_ymod = r_ymod + gda_pkg::YEAR_W'(1);
                    end
                end else begin
                    n_m     = gda_pkg::MONTH_W'(1);
                    n_state = gda_pkg::S_MON;
                end
            end
            gda_pkg::S_MON: begin
                // Walk months until the remainder fits, December taking the rest, then load the free output register.
                alu_b = gda_pkg::ALU_W'(gda_pkg::f_month_len(r_m, leap));
                if (alu_out.gt && (r_m < gda_pkg::MONTH_W'(gda_pkg::MONTHS_PER_YEAR))) begin
                    n_rem = alu_out.res;
                    n_m   = r_m + gda_pkg::MONTH_W'(1);
                end else if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_day   = r_rem[gda_pkg::DAY_W-1:0];
                    n_out_month = r_m;
                    n_out_year  = r_year;
                    n_state     = gda_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gda_pkg::S_IDLE;
            end
        endcase
    end

    // An accepted request always starts with the modulo-400 reduction.
    `GDA_ASSERT_NXT(a_accept_to_ymod, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state == gda_pkg::S_YMOD, "accepted request did not start the year reduction")

    // During and after the year walk, the year modulo 400 stays fully reduced.
    `GDA_ASSERT_IMP(a_ymod_reduced, i_clk, i_rst_n, (r_state == gda_pkg::S_YEAR) || (r_state == gda_pkg::S_MON), r_ymod < gda_pkg::YEAR_W'(gda_pkg::YEARS_PER_CYCLE), "year modulo 400 out of range")

    // The month walk runs within January..December on at most one year of days.
    `GDA_ASSERT_IMP(a_month_walk, i_clk, i_rst_n, r_state == gda_pkg::S_MON, (r_m >= gda_pkg::MONTH_W'(1)) && (r_m <= gda_pkg::MONTH_W'(gda_pkg::MONTHS_PER_YEAR)) && (r_rem <= gda_pkg::ALU_W'(gda_pkg::DAYS_LEAP_YEAR)), "month walk out of range")

endmodule

[sim/testbench.sv]
// Testbench for gregorian_date_add_days: directed and random date requests checked against
// a built-in calendar predictor. Depends on gda_pkg and the channel interfaces in gda_if.sv.
// Both sides idle and stall at random. One long response hold-off forces the input to stall.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_DAYS    = 146097;
    localparam int unsigned CYCLE_YEARS   = 400;
    localparam int unsigned JANUARY       = 1;
    localparam int unsigned FEB           = 2;
    localparam int unsigned DECEMBER      = 12;
    localparam int          RANDOM_ITEMS  = 250;
    localparam int          HOLD_CYCLES   = 600;
    localparam int          DRAIN_CYCLES  = 300;
    localparam int          LIMIT_CYCLES  = 1000000;

    typedef struct packed {
        logic [gda_pkg::DAY_W-1:0]     day;
        logic [gda_pkg::MONTH_W-1:0]   month;
        logic [gda_pkg::YEAR_W-1:0]    year;
        logic [gda_pkg::ADD_WIDTH-1:0] add;
    } t_request;

    typedef struct packed {
        logic [gda_pkg::DAY_W-1:0]   day;
        logic [gda_pkg::MONTH_W-1:0] month;
        logic [gda_pkg::YEAR_W-1:0]  year;
    } t_date;

    logic i_clk;
    logic i_rst_n;

    gda_req_if req_if ();
    gda_rsp_if rsp_if ();

    gregorian_date_add_days uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_request pending_requests[$];
    t_date    expected_dates[$];
    int       total_requests;
    int       accepted_cnt;
    int       error_cnt;
    int       hold_left;
    bit       hold_done;
    int       cycle_cnt;

    // Calendar predictor.
    function automatic bit is_leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            FEB:                   return is_leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic int unsigned days_in_year(input int unsigned y);
        return is_leap_year(y) ? 366 : 365;
    endfunction

    function automatic t_date shift_date(input t_request r);
        int unsigned total;
        int unsigned yr;
        int unsigned mon;
        t_date       d;
        total = 0;
        yr    = r.year;
        // Day of the year of the start date, with the count laid on top.
        for (mon = JANUARY; mon < r.month; mon++) begin
            total += days_in_month(yr, mon);
        end
        total += r.day;
        total += r.add;
        // Skip whole 400-year cycles, then whole years, then months.
        while (total > CYCLE_DAYS) begin
            total -= CYCLE_DAYS;
            yr    += CYCLE_YEARS;
        end
        while (total > days_in_year(yr)) begin
            total -= days_in_year(yr);
            yr++;
        end
        mon = JANUARY;
        while ((total > days_in_month(yr, mon)) && (mon < DECEMBER)) begin
            total -= days_in_month(yr, mon);
            mon++;
        end
        d.day   = gda_pkg::DAY_W'(total);
        d.month = gda_pkg::MONTH_W'(mon);
        d.year  = gda_pkg::YEAR_W'(yr);
        return d;
    endfunction

    // Idle percentages per phase: sender light and receiver heavy, then swapped, then none.
    function automatic int send_idle_pct();
        if (accepted_cnt < total_requests / 3) begin
            return 22;
        end else if (accepted_cnt < 2 * total_requests / 3) begin
            return 87;
        end
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (accepted_cnt < total_requests / 3) begin
            return 87;
        end else if (accepted_cnt < 2 * total_requests / 3) begin
            return 22;
        end
        return 0;
    endfunction

    task automatic report_mismatch(input string what);
        error_cnt++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task automatic queue_request(input int unsigned d, input int unsigned m,
                                 input int unsigned y, input int unsigned a);
        t_request r;
        r.day   = gda_pkg::DAY_W'(d);
        r.month = gda_pkg::MONTH_W'(m);
        r.year  = gda_pkg::YEAR_W'(y);
        r.add   = gda_pkg::ADD_WIDTH'(a);
        pending_requests.push_back(r);
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Request driver: presents queued requests and records the expected date on acceptance.
    always @(posedge i_clk) begin : driver
        t_request next;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_if.valid) begin
                next.day   = req_if.start_day;
                next.month = req_if.start_month;
                next.year  = req_if.start_year;
                next.add   = req_if.days_to_add;
                expected_dates.push_back(shift_date(next));
                accepted_cnt++;
            end
            if ((pending_requests.size() != 0) && ($urandom_range(99) >= send_idle_pct())) begin
                next = pending_requests.pop_front();
                req_if.valid       <= 1'b1;
                req_if.start_day   <= next.day;
                req_if.start_month <= next.month;
                req_if.start_year  <= next.year;
                req_if.days_to_add <= next.add;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Long response hold-off once the idle-free phase begins, so the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && (accepted_cnt >= 2 * total_requests / 3)) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Response monitor: compares each accepted response with the oldest expected date.
    always @(posedge i_clk) begin : monitor
        t_date got;
        t_date want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got.day   = rsp_if.result_day;
                got.month = rsp_if.result_month;
                got.year  = rsp_if.result_year;
                if (expected_dates.size() == 0) begin
                    report_mismatch($sformatf("unexpected response %0d-%0d-%0d",
                                              got.year, got.month, got.day));
                end else begin
                    want = expected_dates.pop_front();
                    if (got != want) begin
                        report_mismatch($sformatf(
                            "got y=%0d m=%0d d=%0d, expected y=%0d m=%0d d=%0d",
                            got.year, got.month, got.day, want.year, want.month, want.day));
                    end
                end
            end
            rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct());
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d dates outstanding",
                     cycle_cnt, expected_dates.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus
        int          i;
        int unsigned m;
        int unsigned y;
        int unsigned a;
        int          pick;

        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.start_day   = '0;
        req_if.start_month = '0;
        req_if.start_year  = '0;
        req_if.days_to_add = '0;
        rsp_if.ready       = 1'b0;
        accepted_cnt       = 0;
        error_cnt          = 0;
        cycle_cnt          = 0;
        hold_left          = 0;
        hold_done          = 1'b0;

        // Directed: field extremes, leap rules and out-of-range months and days.
        queue_request(1, 1, 2024, 0);
        queue_request(0, 1, 2023, 0);         // day zero with nothing added
        queue_request(0, 0, 0, 0);            // all fields at their minimum
        queue_request(31, 15, 16383, 65535);  // all fields at their maximum
        queue_request(31, 12, 16383, 65535);  // result year wraps past 14 bits
        queue_request(31, 12, 1999, 1);
        queue_request(28, 2, 2024, 1);        // leap year
        queue_request(28, 2, 1900, 1);        // century, not leap
        queue_request(28, 2, 2000, 1);        // 400-year leap
        queue_request(31, 2, 2023, 0);        // day beyond month length
        queue_request(31, 0, 2023, 10);       // month zero
        queue_request(5, 13, 2023, 0);        // month past December
        queue_request(5, 15, 2023, 3);
        queue_request(1, 1, 0, 59);           // year zero counts as leap
        queue_request(1, 1, 1, 65535);
        queue_request(15, 6, 9999, 366);
        queue_request(1, 3, 2100, 365);
        queue_request(31, 1, 399, 400);
        queue_request(31, 12, 2399, 1);
        queue_request(31, 12, 2000, 0);
        queue_request(30, 11, 8191, 1000);

        // Random: mostly valid dates, some unrestricted noise.
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(9) < 2) begin
                queue_request($urandom_range(31), $urandom_range(15),
                              $urandom_range(16383), $urandom_range(65535));
            end else begin
                m    = $urandom_range(DECEMBER, JANUARY);
                y    = $urandom_range(9999, 1);
                pick = $urandom_range(9);
                if (pick < 4) begin
                    a = $urandom_range(400);
                end else if (pick < 7) begin
                    a = $urandom_range(5000);
                end else begin
                    a = $urandom_range(65535);
                end
                queue_request($urandom_range(days_in_month(y, m), 1), m, y, a);
            end
        end
        total_requests = pending_requests.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to be taken and every date to come back.
        while ((pending_requests.size() != 0) || req_if.valid || (expected_dates.size() != 0)) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
